// ===== rtl/core/ssfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfc_pkg
// Shared types and constants of the source-heavy Feistel cipher core.
// ----------------------------------------------------------------------------
package ssfc_pkg;

  localparam int WORD_BITS   = 5;
  localparam int ROUND_COUNT = 7;
  localparam int BLK_WORDS   = 4;
  localparam int ENTRY_COUNT = 1 << WORD_BITS;
  localparam int ROUND_BITS  = 3;                     // width of the round_sel field
  localparam int RIDX_BITS   = $clog2(ROUND_COUNT);   // table select width

  typedef logic [WORD_BITS-1:0]                 word_t;
  typedef logic [RIDX_BITS-1:0]                 ridx_t;
  typedef logic [BLK_WORDS-1:0][WORD_BITS-1:0]  blk_t;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_ENC  = 2'd1,
    FUNC_DEC  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  // write port of an s-box bank
  typedef struct packed {
    logic  en;
    ridx_t round;
    word_t addr;
    word_t value;
  } sbox_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssfc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfc_if
// Request and result channels of the cipher core, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssfc_in_if;
  import ssfc_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      func;
  logic [ROUND_BITS-1:0] round_sel;
  word_t           sbox_addr;
  word_t           sbox_value;
  word_t           word_a;
  word_t           word_b;
  word_t           word_c;
  word_t           word_d;

  modport source (
    output valid, func, round_sel, sbox_addr, sbox_value, word_a, word_b, word_c, word_d,
    input  ready
  );

  modport sink (
    input  valid, func, round_sel, sbox_addr, sbox_value, word_a, word_b, word_c, word_d,
    output ready
  );
endinterface

interface ssfc_out_if;
  import ssfc_pkg::*;

  logic  valid;
  logic  ready;
  word_t out_a;
  word_t out_b;
  word_t out_c;
  word_t out_d;

  modport source (
    output valid, out_a, out_b, out_c, out_d,
    input  ready
  );

  modport sink (
    input  valid, out_a, out_b, out_c, out_d,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/small_source_heavy_feistel_cipher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// small_source_heavy_feistel_cipher_core
// Seven-round source-heavy generalized Feistel cipher on four 5-bit words.
// ----------------------------------------------------------------------------
// usage
//   in_chan carries requests: func selects s-box load, encrypt or decrypt.
//   a load writes one entry of one round's s-box and gives no result; an
//   encrypt or decrypt request gives exactly one result on out_chan.
//   func 3 and loads of a round beyond the last are dropped silently.
//   s-box entries must be loaded before a block that reads them is sent.
// timing
//   a request is held in the input register; all rounds are done in one
//   combinational pass from there into the result register, so a result
//   passes the input register and then the result register to out_chan.
//   one request per cycle is taken while out_chan does not stall, set by the
//   input and result registers; loads and blocks keep strict order since
//   both leave the input register in order; loads write the tables only there.
// reset and stall
//   rst_n clears both valid flags; s-box contents stay undefined until loaded.
//   a stalled result holds in the result register; the input register still
//   takes loads and one block, then in_chan.ready drops until out drains.
// ----------------------------------------------------------------------------
module small_source_heavy_feistel_cipher_core (
  input  logic clk,
  input  logic rst_n,
  ssfc_in_if.sink    in_chan,
  ssfc_out_if.source out_chan
);
  import ssfc_pkg::*;

  // word rotations of the block, word 0 is index 0
  function automatic blk_t rot_left(input blk_t b);
    blk_t r;
    r = {b[0], b[3], b[2], b[1]};
    return r;
  endfunction

  function automatic blk_t rot_right(input blk_t b);
    blk_t r;
    r = {b[2], b[1], b[0], b[3]};
    return r;
  endfunction

  // input register
  logic                  s1_v_r, s1_v_nxt;
  func_t                 s1_func_r;
  logic [ROUND_BITS-1:0] s1_round_r;
  word_t                 s1_addr_r;
  word_t                 s1_value_r;
  blk_t                  s1_blk_r;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  blk_t                  out_blk_r;

  // handshake control
  logic s1_is_blk;
  logic s1_is_dec;
  logic out_free;
  logic s1_adv;
  logic in_acc;
  logic out_ld;

  assign s1_is_blk = (s1_func_r == FUNC_ENC) || (s1_func_r == FUNC_DEC);
  assign s1_is_dec = (s1_func_r == FUNC_DEC);
  assign out_free  = !out_valid_r || out_chan.ready;
  // loads and dropped codes leave the input register without a result slot
  assign s1_adv    = s1_v_r && (!s1_is_blk || out_free);
  assign in_chan.ready = !s1_v_r || s1_adv;
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign out_ld    = s1_adv && s1_is_blk;

  assign s1_v_nxt      = in_acc || (s1_v_r && !s1_adv);
  assign out_valid_nxt = out_ld || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= func_t'(in_chan.func);
      s1_round_r <= in_chan.round_sel;
      s1_addr_r  <= in_chan.sbox_addr;
      s1_value_r <= in_chan.sbox_value;
      s1_blk_r   <= {in_chan.word_d, in_chan.word_c, in_chan.word_b, in_chan.word_a};
    end
  end

  // s-box loads: the encrypt bank is indexed by round, the decrypt bank by
  // the stage that uses the round when running backwards
  logic     ld_ok;
  sbox_wr_t enc_wr;
  sbox_wr_t dec_wr;

  assign ld_ok = s1_adv && (s1_func_r == FUNC_LOAD) && (int'(s1_round_r) < ROUND_COUNT);

  assign enc_wr.en    = ld_ok;
  assign enc_wr.round = RIDX_BITS'(s1_round_r);
  assign enc_wr.addr  = s1_addr_r;
  assign enc_wr.value = s1_value_r;

  assign dec_wr.en    = ld_ok;
  assign dec_wr.round = RIDX_BITS'(ROUND_COUNT - 1) - RIDX_BITS'(s1_round_r);
  assign dec_wr.addr  = s1_addr_r;
  assign dec_wr.value = s1_value_r;

  word_t rd_addr  [ROUND_COUNT];
  word_t enc_data [ROUND_COUNT];
  word_t dec_data [ROUND_COUNT];

  ssfc_sbox_bank u_enc_bank (
    .clk     (clk),
    .wr      (enc_wr),
    .rd_addr (rd_addr),
    .rd_data (enc_data)
  );

  ssfc_sbox_bank u_dec_bank (
    .clk     (clk),
    .wr      (dec_wr),
    .rd_addr (rd_addr),
    .rd_data (dec_data)
  );

  // round chain: decrypt rotates right before each round but the first,
  // encrypt rotates left after each round but the last
  blk_t stg [ROUND_COUNT+1];

  assign stg[0] = s1_blk_r;

  for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
    blk_t  pre;
    blk_t  mix;
    word_t key;

    assign pre        = (s1_is_dec && (k != 0)) ? rot_right(stg[k]) : stg[k];
    assign rd_addr[k] = pre[0];
    assign key        = s1_is_dec ? dec_data[k] : enc_data[k];
    assign mix        = {pre[3] ^ key, pre[2] ^ key, pre[1] ^ key, pre[0]};
    assign stg[k+1]   = (!s1_is_dec && (k != ROUND_COUNT - 1)) ? rot_left(mix) : mix;
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_blk_r <= stg[ROUND_COUNT];
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.out_a = out_blk_r[0];
  assign out_chan.out_b = out_blk_r[1];
  assign out_chan.out_c = out_blk_r[2];
  assign out_chan.out_d = out_blk_r[3];

`ifndef SYNTHESIS
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !out_ld)
    else $error("result register overwritten while stalled");

  // a held request blocks the input side
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |-> !in_chan.ready)
    else $error("request taken while input register is held");

  // every block leaving the input register shows up as a result
  a_block_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> out_valid_r)
    else $error("block left input register without a result");

  // encrypt-bank writes only come from a load in the input register
  a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
    enc_wr.en |-> (s1_v_r && (s1_func_r == FUNC_LOAD) && !out_ld))
    else $error("s-box written outside a load");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ssfc_sbox_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfc_sbox_bank
// One s-box per stage, flop based, one shared write port and one read port per stage.
// ----------------------------------------------------------------------------
module ssfc_sbox_bank (
  input  logic                clk,
  input  ssfc_pkg::sbox_wr_t  wr,
  input  ssfc_pkg::word_t     rd_addr [ssfc_pkg::ROUND_COUNT],
  output ssfc_pkg::word_t     rd_data [ssfc_pkg::ROUND_COUNT]
);
  import ssfc_pkg::*;

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_stage
    word_t tbl_r [ENTRY_COUNT];

    // contents are undefined until loaded
    always_ff @(posedge clk) begin
      if (wr.en && (wr.round == RIDX_BITS'(g))) begin
        tbl_r[wr.addr] <= wr.value;
      end
    end

    assign rd_data[g] = tbl_r[rd_addr[g]];
  end

endmodule

`default_nettype wire
